/* rtl/shtc_pkg.sv */
// Package of the scheduled hysteresis thermostat.
// Holds the shared types, codes and reset constants; no dependencies.
package shtc_pkg;

    // Item codes
    localparam logic ACT_WRITE   = 1'b0;
    localparam logic ACT_CONTROL = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 4;
    localparam logic [CFG_INDEX_W-1:0] CFG_HYSTERESIS       = 4'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_HOT_WATER_THRESH = 4'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SENSOR_MASK      = 4'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_SETPOINT = 4'd3;

    // Reset values
    localparam logic        [4:0] HYSTERESIS_RESET = 5'd2;
    localparam logic signed [7:0] HOT_WATER_RESET  = 8'sd40;
    localparam logic        [7:0] SENSOR_MASK_RESET = 8'd0;
    localparam logic signed [7:0] DEFAULT_SETPOINT = 8'sd20;

    // Queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = 1;

    typedef struct packed {
        logic              action;
        logic        [2:0] zone;
        logic        [2:0] slot;
        logic       [10:0] entry_time;
        logic signed [7:0] entry_temp;
        logic       [10:0] time_of_day;
        logic signed [7:0] measured_temp;
    } q_entry_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef struct packed {
        logic        [4:0] hysteresis;
        logic signed [7:0] hot_water_threshold;
        logic        [7:0] sensor_present_mask;
    } cfg_t;

    typedef struct packed {
        logic       [10:0] stime;
        logic signed [7:0] stemp;
    } point_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_SCAN,
        B_DECIDE
    } back_state_t;

endpackage

/* rtl/shtc_if.sv */
// Channel interfaces of the thermostat: request, result and configuration.
// Fixed field widths; no dependencies.
interface shtc_in_if;
    logic              valid;
    logic              ready;
    logic              action;
    logic        [2:0] zone;
    logic        [2:0] slot;
    logic       [10:0] entry_time;
    logic signed [7:0] entry_temp;
    logic       [10:0] time_of_day;
    logic signed [7:0] measured_temp;

    modport source (output valid, action, zone, slot, entry_time, entry_temp,
                    time_of_day, measured_temp, input ready);
    modport sink   (input valid, action, zone, slot, entry_time, entry_temp,
                    time_of_day, measured_temp, output ready);
endinterface

interface shtc_out_if;
    logic              valid;
    logic              ready;
    logic        [2:0] out_zone;
    logic signed [7:0] setpoint;
    logic              heat_on;
    logic signed [7:0] zone_temp;

    modport source (output valid, out_zone, setpoint, heat_on, zone_temp, input ready);
    modport sink   (input valid, out_zone, setpoint, heat_on, zone_temp, output ready);
endinterface

interface shtc_cfg_if;
    logic       valid;
    logic       ready;
    logic [3:0] index;
    logic [7:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/shtc_front.sv */
// Front part: accepts request transactions and classifies them.
// Drops items for absent zones or slots; depends on shtc_pkg and shtc_if.
module shtc_front #(
    parameter int POINTS_PER_ZONE = 8,
    parameter int NUM_ZONES       = 8
) (
    shtc_in_if.sink            req,
    input  shtc_pkg::q_status_t q_status,
    output logic               push,
    output shtc_pkg::q_entry_t entry
);
    import shtc_pkg::*;

    logic keep;

    assign req.ready = !q_status.full;

    always_comb
    begin
        keep = (32'(req.zone) < NUM_ZONES) &&
               ((req.action == ACT_CONTROL) || (32'(req.slot) < POINTS_PER_ZONE));
    end

    assign push = req.valid && req.ready && keep;

    always_comb
    begin
        entry.action        = req.action;
        entry.zone          = req.zone;
        entry.slot          = req.slot;
        entry.entry_time    = req.entry_time;
        entry.entry_temp    = req.entry_temp;
        entry.time_of_day   = req.time_of_day;
        entry.measured_temp = req.measured_temp;
    end

endmodule

/* rtl/shtc_queue.sv */
// Short queue between the front and back parts of the thermostat.
// Two entries of q_entry_t; depends on shtc_pkg.
module shtc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  shtc_pkg::q_entry_t entry_in,
    input  logic               pop,
    output shtc_pkg::q_entry_t entry_out,
    output shtc_pkg::q_status_t status
);
    import shtc_pkg::*;

    q_entry_t                 slots_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]   wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]   rd_ptr_reg;
    logic [QUEUE_PTR_W:0]     count_reg;
    logic [QUEUE_PTR_W:0]     count_next;

    assign status.empty = (count_reg == '0);
    assign status.full  = (count_reg == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign entry_out    = slots_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= entry_in;
        end
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.full |-> !push)
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        status.empty |-> !pop)
        else $error("queue read while empty");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue count did not follow a lone write");
`endif

endmodule

/* rtl/shtc_back.sv */
// Back part: schedule memory, point scan, hysteresis decision and result register.
// Depends on shtc_pkg and shtc_if.
module shtc_back #(
    parameter int POINTS_PER_ZONE = 8,
    parameter int NUM_ZONES       = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  shtc_pkg::cfg_t      cfg,
    input  shtc_pkg::q_entry_t  q_head,
    input  shtc_pkg::q_status_t q_status,
    output logic                q_pop,
    shtc_out_if.source          rsp
);
    import shtc_pkg::*;

    localparam int DEPTH = NUM_ZONES * POINTS_PER_ZONE;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = $clog2(POINTS_PER_ZONE);
    localparam int ZW    = (NUM_ZONES > 1) ? $clog2(NUM_ZONES) : 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(POINTS_PER_ZONE - 1);

    function automatic logic [AW-1:0] addr_of(input logic [2:0] z, input logic [IW-1:0] i);
        addr_of = AW'(32'(z) * POINTS_PER_ZONE + 32'(i));
    endfunction

    // Schedule memory; a point never written reads as its reset value.
    point_t            mem [DEPTH];
    logic              pt_valid_reg [DEPTH];
    point_t            rd_data_reg;
    logic              rd_valid_reg;
    logic [AW-1:0]     rd_addr;
    logic              mem_we;
    logic [AW-1:0]     wr_addr;
    point_t            wr_data;

    back_state_t       state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic [IW-1:0]     rd_idx;
    logic [2:0]        zone_reg, zone_next;
    logic [10:0]       now_reg, now_next;
    logic signed [7:0] meas_reg, meas_next;
    logic signed [7:0] temp0_reg, temp0_next;
    logic signed [7:0] prev_reg, prev_next;
    logic signed [7:0] sp_reg, sp_next;

    logic              heat_on_reg [NUM_ZONES];
    logic signed [7:0] last_temp_reg [NUM_ZONES];
    logic              zone_we;
    logic              heat_new;
    logic              sensor;
    logic [ZW-1:0]     zi;

    logic              out_valid_reg, out_valid_next;
    logic [2:0]        out_zone_reg, out_zone_next;
    logic signed [7:0] out_sp_reg, out_sp_next;
    logic              out_heat_reg, out_heat_next;
    logic signed [7:0] out_ztemp_reg, out_ztemp_next;
    logic              out_free;

    logic       [10:0] t_eff;
    logic signed [7:0] temp_eff;
    logic signed [9:0] low_limit;
    logic signed [9:0] meas_wide;

    assign out_free  = !out_valid_reg || rsp.ready;
    assign zi        = ZW'(zone_reg);
    assign sensor    = cfg.sensor_present_mask[zone_reg];
    assign wr_addr   = addr_of(q_head.zone, IW'(q_head.slot));
    assign wr_data   = '{stime: q_head.entry_time, stemp: q_head.entry_temp};
    assign rd_idx    = (idx_reg == LAST_IDX) ? idx_reg : idx_reg + 1'b1;
    assign t_eff     = rd_valid_reg ? rd_data_reg.stime : '0;
    assign low_limit = 10'(sp_reg) - $signed({5'b0, cfg.hysteresis});
    assign meas_wide = 10'(meas_reg);

    always_comb
    begin
        if (rd_valid_reg)
        begin
            temp_eff = rd_data_reg.stemp;
        end
        else if (idx_reg == '0)
        begin
            temp_eff = DEFAULT_SETPOINT;
        end
        else
        begin
            temp_eff = '0;
        end
    end

    // Thermostat decision for the zone being controlled.
    always_comb
    begin
        heat_new = heat_on_reg[zi];
        if (!sensor)
        begin
            heat_new = (sp_reg > cfg.hot_water_threshold);
        end
        else if (heat_on_reg[zi])
        begin
            if (meas_reg > sp_reg)
            begin
                heat_new = 1'b0;
            end
        end
        else if (meas_wide < low_limit)
        begin
            heat_new = 1'b1;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        zone_next      = zone_reg;
        now_next       = now_reg;
        meas_next      = meas_reg;
        temp0_next     = temp0_reg;
        prev_next      = prev_reg;
        sp_next        = sp_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        zone_we        = 1'b0;
        rd_addr        = addr_of(zone_reg, rd_idx);
        out_valid_next = out_valid_reg && !rsp.ready;
        out_zone_next  = out_zone_reg;
        out_sp_next    = out_sp_reg;
        out_heat_next  = out_heat_reg;
        out_ztemp_next = out_ztemp_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (!q_status.empty)
                begin
                    q_pop = 1'b1;
                    if (q_head.action == ACT_WRITE)
                    begin
                        mem_we = 1'b1;
                    end
                    else
                    begin
                        zone_next  = q_head.zone;
                        now_next   = q_head.time_of_day;
                        meas_next  = q_head.measured_temp;
                        idx_next   = '0;
                        rd_addr    = addr_of(q_head.zone, '0);
                        state_next = B_SCAN;
                    end
                end
            end
            B_SCAN:
            begin
                // Data for point idx_reg is in the read register this cycle.
                if (idx_reg == '0)
                begin
                    temp0_next = temp_eff;
                    prev_next  = temp_eff;
                    idx_next   = idx_reg + 1'b1;
                end
                else if ((t_eff == '0) || (t_eff > now_reg))
                begin
                    sp_next    = prev_reg;
                    state_next = B_DECIDE;
                end
                else if (idx_reg == LAST_IDX)
                begin
                    // No point stopped the scan: wrap to the first one.
                    sp_next    = temp0_reg;
                    state_next = B_DECIDE;
                end
                else
                begin
                    prev_next = temp_eff;
                    idx_next  = idx_reg + 1'b1;
                end
            end
            B_DECIDE:
            begin
                if (out_free)
                begin
                    zone_we        = 1'b1;
                    out_valid_next = 1'b1;
                    out_zone_next  = zone_reg;
                    out_sp_next    = sp_reg;
                    out_heat_next  = heat_new;
                    out_ztemp_next = sensor ? meas_reg : last_temp_reg[zi];
                    state_next     = B_IDLE;
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= B_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg       <= idx_next;
        zone_reg      <= zone_next;
        now_reg       <= now_next;
        meas_reg      <= meas_next;
        temp0_reg     <= temp0_next;
        prev_reg      <= prev_next;
        sp_reg        <= sp_next;
        out_zone_reg  <= out_zone_next;
        out_sp_reg    <= out_sp_next;
        out_heat_reg  <= out_heat_next;
        out_ztemp_reg <= out_ztemp_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                pt_valid_reg[i] <= 1'b0;
            end
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (mem_we)
            begin
                pt_valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= pt_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_ZONES; i++)
            begin
                heat_on_reg[i]   <= 1'b1;
                last_temp_reg[i] <= '0;
            end
        end
        else if (zone_we)
        begin
            heat_on_reg[zi] <= heat_new;
            if (sensor)
            begin
                last_temp_reg[zi] <= meas_reg;
            end
        end
    end

    assign rsp.valid    = out_valid_reg;
    assign rsp.out_zone = out_zone_reg;
    assign rsp.setpoint = out_sp_reg;
    assign rsp.heat_on  = out_heat_reg;
    assign rsp.zone_temp = out_ztemp_reg;

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> (state_reg == B_IDLE))
        else $error("queue popped outside idle");
    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != B_IDLE) |-> !mem_we)
        else $error("schedule written during a control scan");
    a_scan_start: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_IDLE && state_next == B_SCAN) |=>
            (state_reg == B_SCAN && idx_reg == '0))
        else $error("scan did not start at the first point");
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == B_DECIDE && out_free) |=> (out_valid_reg && state_reg == B_IDLE))
        else $error("decision did not load the result register");
`endif

endmodule

/* rtl/scheduled_hysteresis_thermostat_top.sv */
// Top level of the scheduled hysteresis thermostat: configuration registers
// and the front, queue and back parts. Depends on shtc_pkg and shtc_if.
//
// Usage:
//   req carries items. action write stores a schedule point (time, temperature)
//   of a zone; action control scans that zone's schedule at time_of_day and
//   runs the thermostat, giving one transaction on rsp. Writes and items for
//   absent zones or slots give no result.
//   cfg writes hysteresis, hot-water threshold and sensor mask by index; it is
//   always ready. Default setpoint writes are accepted and change nothing.
//   A control item is taken from the queue in idle; the scan then reads one
//   schedule point per cycle from the single read port of the schedule memory,
//   and the decision loads the result register once that register is free.
//   A write item is stored from the queue head while the back part is idle.
//   The back part takes a new item only after it is through with the last.
//   A two-entry queue lets req keep accepting while the back part works.
//   When rsp stalls, the result waits in its register, the back part holds
//   the next decision and the queue fills before req.ready drops.
//   Reset clears the queue and result register; schedules read as empty with
//   point 0 at the default setpoint, all zones heating, stored temperatures 0.
module scheduled_hysteresis_thermostat_top #(
    parameter int POINTS_PER_ZONE = 8,
    parameter int NUM_ZONES       = 8
) (
    input  logic       clk,
    input  logic       rst_n,
    shtc_in_if.sink    req,
    shtc_out_if.source rsp,
    shtc_cfg_if.sink   cfg
);
    import shtc_pkg::*;

    cfg_t      cfg_reg;
    q_entry_t  push_entry;
    q_entry_t  head_entry;
    q_status_t q_status;
    logic      push;
    logic      pop;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis          <= HYSTERESIS_RESET;
            cfg_reg.hot_water_threshold <= HOT_WATER_RESET;
            cfg_reg.sensor_present_mask <= SENSOR_MASK_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            case (cfg.index)
                CFG_HYSTERESIS:       cfg_reg.hysteresis          <= cfg.data[4:0];
                CFG_HOT_WATER_THRESH: cfg_reg.hot_water_threshold <= $signed(cfg.data);
                CFG_SENSOR_MASK:      cfg_reg.sensor_present_mask <= cfg.data;
                CFG_DEFAULT_SETPOINT: ;
                default: ;
            endcase
        end
    end

    shtc_front #(
        .POINTS_PER_ZONE (POINTS_PER_ZONE),
        .NUM_ZONES       (NUM_ZONES)
    ) u_front (
        .req      (req),
        .q_status (q_status),
        .push     (push),
        .entry    (push_entry)
    );

    shtc_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .entry_in  (push_entry),
        .pop       (pop),
        .entry_out (head_entry),
        .status    (q_status)
    );

    shtc_back #(
        .POINTS_PER_ZONE (POINTS_PER_ZONE),
        .NUM_ZONES       (NUM_ZONES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .q_head   (head_entry),
        .q_status (q_status),
        .q_pop    (pop),
        .rsp      (rsp)
    );

endmodule
